// ===== sv/lpod_pkg.sv =====
package lpod_pkg;

    localparam int PACKET_BYTES      = 47;
    localparam int POINTS_PER_PACKET = 12;
    localparam int BODY_BYTES        = PACKET_BYTES - 1;
    localparam int ADDR_W            = $clog2(BODY_BYTES);
    localparam int DIFF_W            = 17;

    localparam logic [7:0]  HDR_BYTE   = 8'h54;
    localparam logic [7:0]  VER_BYTE   = 8'h2C;
    localparam logic [13:0] NONE_MM    = 14'd9999;
    localparam logic [16:0] FULL_TURN  = 17'd36000;
    localparam logic [16:0] TICK_MAX   = 17'd131071;
    localparam logic [3:0]  PT_DIV     = 4'd11;

    // Reciprocal of the point divisor, exact for every dividend below 2**17.
    localparam int          RECIP_SH   = 21;
    localparam logic [17:0] RECIP_11   = 18'd190651;

    localparam logic [ADDR_W-1:0] POS_START_LO = ADDR_W'(3);
    localparam logic [ADDR_W-1:0] POS_START_HI = ADDR_W'(4);
    localparam logic [ADDR_W-1:0] POS_STOP_LO  = ADDR_W'(5 + 3 * POINTS_PER_PACKET);
    localparam logic [ADDR_W-1:0] POS_STOP_HI  = ADDR_W'(6 + 3 * POINTS_PER_PACKET);
    localparam logic [ADDR_W-1:0] POS_POINTS   = ADDR_W'(5);

    localparam logic [2:0] REG_MIN_CONF  = 3'd0;
    localparam logic [2:0] REG_MAX_DIST  = 3'd1;
    localparam logic [2:0] REG_STOP_DIST = 3'd2;
    localparam logic [2:0] REG_HOLD      = 3'd3;
    localparam logic [2:0] REG_FRONT_LO  = 3'd4;
    localparam logic [2:0] REG_FRONT_HI  = 3'd5;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;
    localparam logic KIND_POINT  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DIV  = 9'b000000010,
        S_RD0  = 9'b000000100,
        S_RD1  = 9'b000001000,
        S_RD2  = 9'b000010000,
        S_RD3  = 9'b000100000,
        S_MOD  = 9'b001000000,
        S_EMIT = 9'b010000000,
        S_SEND = 9'b100000000
    } t_state;

endpackage

// ===== sv/lidar_packet_obstacle_detect.sv =====
// Serial bytes and ticks are accepted only while the block is idle.
// The last byte of a good packet starts a reciprocal divide of the angle span by eleven,
// then a shared angle unit walks the twelve points, held by output stalls, and a status
// transaction closes the packet; the input is ready again once that status is taken.
// Reset is synchronous and active low; it clears control state and restores
// the register defaults. The packet byte memory is not cleared.
module lidar_packet_obstacle_detect (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // rx_byte
    input  logic        i_s_axis_tuser,   // action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // angle_cd, distance_mm, confidence, obstacle, nearest_mm, zero pad
    output logic [55:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser,   // kind
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);
    import lpod_pkg::*;

    t_state r_state;

    logic [7:0]  r_min_conf;
    logic [15:0] r_max_dist, r_stop_dist, r_hold, r_front_lo, r_front_hi;

    logic [7:0]  r_mem [BODY_BYTES];
    logic [7:0]  r_rd;
    logic [ADDR_W-1:0] r_cnt;
    logic        r_in_packet;
    logic        r_ver_ok;
    logic [15:0] r_start, r_stop;

    logic        r_flag;
    logic [13:0] r_nearest;
    logic [16:0] r_ticks;

    logic [DIFF_W-1:0] r_div;
    logic [3:0]  r_rem;
    logic        r_div_ph;
    logic [DIFF_W-1:0] r_q;
    logic [3:0]  r_r;
    logic [3:0]  r_idx;
    logic [ADDR_W-1:0] r_base;
    logic [17:0] r_ang;
    logic [15:0] r_dist;
    logic [7:0]  r_conf;
    logic        r_hit;
    logic [13:0] r_near;

    logic        r_tvalid;
    logic [55:0] r_tdata;
    logic        r_tuser, r_tlast;

    logic        w_in_acc;
    logic [ADDR_W-1:0] w_addr;
    logic [16:0] w_stop_adj;
    logic [DIFF_W-1:0] w_diff;
    logic [34:0] w_prod;
    logic [DIFF_W-1:0] w_rem_full;
    logic [4:0]  w_r_sum;
    logic        w_keep, w_front, w_hit_pt;
    logic        n_flag;
    logic [13:0] n_nearest;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_tvalid;
    assign o_m_axis_tdata  = r_tdata;
    assign o_m_axis_tuser  = r_tuser;
    assign o_m_axis_tlast  = r_tlast;

    always_comb begin
        unique case (r_state)
            S_RD1:   w_addr = r_base + ADDR_W'(1);
            S_RD2:   w_addr = r_base + ADDR_W'(2);
            default: w_addr = r_base;
        endcase
    end

    always_comb begin
        w_stop_adj = (r_stop < r_start) ? ({1'b0, r_stop} + FULL_TURN) : {1'b0, r_stop};
        w_diff     = w_stop_adj - {1'b0, r_start};
        w_prod     = {18'd0, r_div} * {17'd0, RECIP_11};
        w_rem_full = r_div - ((r_q << 3) + (r_q << 1) + r_q);
        w_r_sum    = {1'b0, r_r} + {1'b0, r_rem};
        w_keep     = !(r_conf < r_min_conf) && (r_dist != 16'd0) && !(r_dist > r_max_dist);
        w_front    = (r_ang[15:0] >= r_front_lo) || (r_ang[15:0] <= r_front_hi);
        w_hit_pt   = w_keep && w_front && (r_dist < r_stop_dist);
        n_flag     = r_flag;
        n_nearest  = r_nearest;
        if (r_hit) begin
            n_flag    = 1'b1;
            n_nearest = r_near;
        end else if (r_flag && (r_ticks > {1'b0, r_hold})) begin
            n_flag    = 1'b0;
            n_nearest = NONE_MM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_s_axis_tuser == ACT_BYTE && r_in_packet) begin
            r_mem[r_cnt] <= i_s_axis_tdata;
        end
        r_rd <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_conf  <= 8'd100;
            r_max_dist  <= 16'd12000;
            r_stop_dist <= 16'd350;
            r_hold      <= 16'd400;
            r_front_lo  <= 16'd33000;
            r_front_hi  <= 16'd3000;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_MIN_CONF:  r_min_conf  <= i_cfg_wdata[7:0];
                REG_MAX_DIST:  r_max_dist  <= i_cfg_wdata;
                REG_STOP_DIST: r_stop_dist <= i_cfg_wdata;
                REG_HOLD:      r_hold      <= i_cfg_wdata;
                REG_FRONT_LO:  r_front_lo  <= i_cfg_wdata;
                REG_FRONT_HI:  r_front_hi  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_in_packet <= 1'b0;
            r_flag      <= 1'b0;
            r_nearest   <= NONE_MM;
            r_ticks     <= '0;
            r_tvalid    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_s_axis_tuser == ACT_TICK) begin
                            if (r_ticks < TICK_MAX) r_ticks <= r_ticks + 17'd1;
                        end else if (!r_in_packet) begin
                            if (i_s_axis_tdata == HDR_BYTE) begin
                                r_in_packet <= 1'b1;
                                r_cnt       <= '0;
                            end
                        end else begin
                            if (r_cnt == '0) r_ver_ok <= (i_s_axis_tdata == VER_BYTE);
                            if (r_cnt == POS_START_LO) r_start[7:0]  <= i_s_axis_tdata;
                            if (r_cnt == POS_START_HI) r_start[15:8] <= i_s_axis_tdata;
                            if (r_cnt == POS_STOP_LO)  r_stop[7:0]   <= i_s_axis_tdata;
                            if (r_cnt == POS_STOP_HI)  r_stop[15:8]  <= i_s_axis_tdata;
                            if (r_cnt == ADDR_W'(BODY_BYTES - 1)) begin
                                r_in_packet <= 1'b0;
                                r_cnt       <= '0;
                                if (r_ver_ok) begin
                                    r_state  <= S_DIV;
                                    r_div    <= w_diff;
                                    r_div_ph <= 1'b0;
                                end
                            end else begin
                                r_cnt <= r_cnt + ADDR_W'(1);
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (!r_div_ph) begin
                        r_q      <= DIFF_W'(w_prod[34:RECIP_SH]);
                        r_div_ph <= 1'b1;
                    end else begin
                        r_div   <= r_q;
                        r_rem   <= w_rem_full[3:0];
                        r_state <= S_RD0;
                        r_q     <= '0;
                        r_r     <= '0;
                        r_idx   <= '0;
                        r_base  <= POS_POINTS;
                        r_hit   <= 1'b0;
                        r_near  <= NONE_MM;
                    end
                end
                S_RD0: begin
                    r_ang   <= {2'b0, r_start} + {1'b0, r_q};
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_dist[7:0] <= r_rd;
                    r_state     <= S_RD2;
                end
                S_RD2: begin
                    r_dist[15:8] <= r_rd;
                    r_state      <= S_RD3;
                end
                S_RD3: begin
                    r_conf  <= r_rd;
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (r_ang >= {1'b0, FULL_TURN}) begin
                        r_ang <= r_ang - {1'b0, FULL_TURN};
                    end else begin
                        if (w_hit_pt) begin
                            r_hit <= 1'b1;
                            if (r_dist < {2'b0, r_near}) r_near <= r_dist[13:0];
                        end
                        if (w_keep) begin
                            r_tvalid <= 1'b1;
                            r_tuser  <= KIND_POINT;
                            r_tlast  <= 1'b0;
                            r_tdata  <= {16'd0, r_conf, r_dist, r_ang[15:0]};
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_tvalid || i_m_axis_tready) begin
                        r_idx    <= r_idx + 4'd1;
                        r_base   <= r_base + ADDR_W'(3);
                        if (w_r_sum >= {1'b0, PT_DIV}) begin
                            r_r <= 4'(w_r_sum - {1'b0, PT_DIV});
                            r_q <= r_q + r_div + DIFF_W'(1);
                        end else begin
                            r_r <= w_r_sum[3:0];
                            r_q <= r_q + r_div;
                        end
                        if (r_idx == 4'(POINTS_PER_PACKET - 1)) begin
                            r_flag    <= n_flag;
                            r_nearest <= n_nearest;
                            if (r_hit) r_ticks <= '0;
                            r_tvalid  <= 1'b1;
                            r_tuser   <= KIND_STATUS;
                            r_tlast   <= 1'b1;
                            r_tdata   <= {1'b0, n_nearest, n_flag, 40'd0};
                            r_state   <= S_SEND;
                        end else begin
                            r_tvalid <= 1'b0;
                            r_state  <= S_RD0;
                        end
                    end
                end
                S_SEND: begin
                    if (i_m_axis_tready) begin
                        r_tvalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import lpod_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [15:0] angle_cd;
        logic [15:0] distance_mm;
        logic [7:0]  confidence;
        logic        obstacle;
        logic [13:0] nearest_mm;
        logic        last;
    } t_result;

    typedef struct {
        logic       action;
        logic [7:0] rx_byte;
    } t_item;

    // One directed packet: ticks sent before it, whether the permissive register
    // set is written first, the version byte, raw angles and the point pattern.
    typedef struct {
        int         ticks;
        bit         open_regs;
        logic [7:0] ver;
        int         start;
        int         stop;
        int         pattern;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [55:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_wdata;

    lidar_packet_obstacle_detect uut (.*);

    // Predictor state and register copies.
    logic [7:0]  body [0:BODY_BYTES-1];
    int          body_count;
    bit          hunting_done;
    bit          flag_q;
    logic [13:0] near_q;
    int          tick_count;
    int          cfg_min_conf, cfg_max_dist, cfg_stop, cfg_hold, cfg_flo, cfg_fhi;

    t_result     expected_results[$];
    int          errors;
    int          send_idle_pct, recv_idle_pct;

    t_dir_row    dir_rows[4] = '{
        '{2, 1'b0, VER_BYTE, 35000, 1000,  0},
        '{0, 1'b0, 8'h2D,    0,     0,     0},
        '{0, 1'b0, VER_BYTE, 65535, 40000, 1},
        '{3, 1'b1, VER_BYTE, 0,     35999, 1}
    };

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int rd16(int pos);
        return int'(body[pos]) | (int'(body[pos + 1]) << 8);
    endfunction

    task automatic predict_packet_end();
        int start, stop, span, pt_dist, conf, ang, near;
        bit hit;
        t_result r;
        if (body[0] != VER_BYTE) return;
        hit = 0;
        near = NONE_MM;
        start = rd16(3);
        stop = rd16(5 + 3 * POINTS_PER_PACKET);
        if (stop < start) stop += FULL_TURN;
        span = stop - start;
        for (int i = 0; i < POINTS_PER_PACKET; i++) begin
            pt_dist = rd16(5 + 3 * i);
            conf = body[7 + 3 * i];
            if (conf < cfg_min_conf || pt_dist == 0 || pt_dist > cfg_max_dist) continue;
            ang = (start + (span * i) / (POINTS_PER_PACKET - 1)) % FULL_TURN;
            r = '0;
            r.kind = KIND_POINT;
            r.angle_cd = ang[15:0];
            r.distance_mm = pt_dist[15:0];
            r.confidence = conf[7:0];
            expected_results.push_back(r);
            if ((ang >= cfg_flo || ang <= cfg_fhi) && pt_dist < cfg_stop) begin
                hit = 1;
                if (pt_dist < near) near = pt_dist;
            end
        end
        if (hit) begin
            flag_q = 1;
            near_q = near[13:0];
            tick_count = 0;
        end else if (flag_q && tick_count > cfg_hold) begin
            flag_q = 0;
            near_q = NONE_MM;
        end
        r = '0;
        r.kind = KIND_STATUS;
        r.obstacle = flag_q;
        r.nearest_mm = near_q;
        r.last = 1'b1;
        expected_results.push_back(r);
    endtask

    task automatic predict_item(t_item it);
        if (it.action == ACT_TICK) begin
            if (tick_count < TICK_MAX) tick_count++;
        end else if (!hunting_done) begin
            if (it.rx_byte == HDR_BYTE) begin
                hunting_done = 1;
                body_count = 0;
            end
        end else begin
            body[body_count] = it.rx_byte;
            body_count++;
            if (body_count == BODY_BYTES) begin
                hunting_done = 0;
                body_count = 0;
                predict_packet_end();
            end
        end
    endtask

    task automatic send_item(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= it.action;
        i_s_axis_tdata <= it.rx_byte;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_item(it);
    endtask

    task automatic write_reg(logic [2:0] idx, int value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value[15:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_MIN_CONF:  cfg_min_conf = value & 8'hFF;
            REG_MAX_DIST:  cfg_max_dist = value & 16'hFFFF;
            REG_STOP_DIST: cfg_stop = value & 16'hFFFF;
            REG_HOLD:      cfg_hold = value & 16'hFFFF;
            REG_FRONT_LO:  cfg_flo = value & 16'hFFFF;
            REG_FRONT_HI:  cfg_fhi = value & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] b);
        t_item it;
        it.action = ACT_BYTE;
        it.rx_byte = b;
        send_item(it);
    endtask

    task automatic send_ticks(int n);
        t_item it;
        it.action = ACT_TICK;
        for (int k = 0; k < n; k++) begin
            it.rx_byte = 8'($urandom_range(255));
            send_item(it);
        end
    endtask

    // Pattern 0 holds the filter extremes, pattern 1 header bytes as data.
    task automatic fill_pattern(int pattern, output int dists[12], output int confs[12]);
        for (int i = 0; i < 12; i++) begin
            if (pattern == 0) begin
                dists[i] = (i == 0) ? 100 : (i == 1) ? 0 : (i == 2) ? 12001 : 65535 - i;
                confs[i] = (i == 3) ? 99 : 255;
            end else begin
                dists[i] = (i % 2) ? HDR_BYTE : 5000;
                confs[i] = HDR_BYTE;
            end
        end
    endtask

    // Sends a header and 46 body bytes built from the given point set.
    task automatic send_packet(logic [7:0] ver, int start, int stop,
                               int dists[12], int confs[12]);
        logic [7:0] pk [0:BODY_BYTES-1];
        pk[0] = ver;
        pk[1] = 8'($urandom_range(255));
        pk[2] = 8'($urandom_range(255));
        pk[3] = start[7:0];
        pk[4] = start[15:8];
        for (int i = 0; i < 12; i++) begin
            pk[5 + 3 * i] = dists[i][7:0];
            pk[6 + 3 * i] = dists[i][15:8];
            pk[7 + 3 * i] = confs[i][7:0];
        end
        pk[41] = stop[7:0];
        pk[42] = stop[15:8];
        pk[43] = 8'($urandom_range(255));
        pk[44] = 8'($urandom_range(255));
        pk[45] = 8'($urandom_range(255));
        send_byte(HDR_BYTE);
        for (int i = 0; i < BODY_BYTES; i++) send_byte(pk[i]);
    endtask

    task automatic random_packet(bit near_front);
        int dists[12], confs[12];
        int start, stop;
        start = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(35999);
        stop = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(35999);
        for (int i = 0; i < 12; i++) begin
            case ($urandom_range(5))
                0: dists[i] = 0;
                1: dists[i] = $urandom_range(65535);
                2: dists[i] = $urandom_range(600);
                default: dists[i] = near_front ? $urandom_range(1, 400)
                                               : $urandom_range(1, 12000);
            endcase
            confs[i] = $urandom_range(255);
        end
        send_packet(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : VER_BYTE,
                    start, stop, dists, confs);
    endtask

    // Results are sampled at the rising edge with the ready the bench drove.
    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.kind = o_m_axis_tuser;
            got.angle_cd = o_m_axis_tdata[15:0];
            got.distance_mm = o_m_axis_tdata[31:16];
            got.confidence = o_m_axis_tdata[39:32];
            got.obstacle = o_m_axis_tdata[40];
            got.nearest_mm = o_m_axis_tdata[54:41];
            got.last = o_m_axis_tlast;
            if (expected_results.size() == 0) begin
                $error("unexpected transaction kind=%0d", got.kind);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.kind !== exp_r.kind) begin
                    $error("kind: expected %0d, got %0d", exp_r.kind, got.kind);
                    errors++;
                end
                if (got.angle_cd !== exp_r.angle_cd) begin
                    $error("angle_cd: expected %0d, got %0d", exp_r.angle_cd, got.angle_cd);
                    errors++;
                end
                if (got.distance_mm !== exp_r.distance_mm) begin
                    $error("distance_mm: expected %0d, got %0d",
                           exp_r.distance_mm, got.distance_mm);
                    errors++;
                end
                if (got.confidence !== exp_r.confidence) begin
                    $error("confidence: expected %0d, got %0d",
                           exp_r.confidence, got.confidence);
                    errors++;
                end
                if (got.obstacle !== exp_r.obstacle) begin
                    $error("obstacle: expected %0d, got %0d", exp_r.obstacle, got.obstacle);
                    errors++;
                end
                if (got.nearest_mm !== exp_r.nearest_mm) begin
                    $error("nearest_mm: expected %0d, got %0d",
                           exp_r.nearest_mm, got.nearest_mm);
                    errors++;
                end
                if (got.last !== exp_r.last) begin
                    $error("last: expected %0d, got %0d", exp_r.last, got.last);
                    errors++;
                end
            end
        end
        if (i_rst_n) i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        int dists[12], confs[12];
        errors = 0;
        send_idle_pct = 20;
        recv_idle_pct = 46;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        i_m_axis_tready = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        hunting_done = 0;
        body_count = 0;
        flag_q = 0;
        near_q = NONE_MM;
        tick_count = 0;
        cfg_min_conf = 100;
        cfg_max_dist = 12000;
        cfg_stop = 350;
        cfg_hold = 400;
        cfg_flo = 33000;
        cfg_fhi = 3000;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset registers, extremes, bad version, permissive registers.
        send_byte(8'h00);
        send_byte(8'hFF);
        foreach (dir_rows[k]) begin
            if (dir_rows[k].open_regs) begin
                drain();
                write_reg(REG_HOLD, 0);
                write_reg(REG_MIN_CONF, 0);
                write_reg(REG_MAX_DIST, 65535);
                write_reg(REG_STOP_DIST, 65535);
                write_reg(REG_FRONT_LO, 35999);
                write_reg(REG_FRONT_HI, 0);
            end
            send_ticks(dir_rows[k].ticks);
            fill_pattern(dir_rows[k].pattern, dists, confs);
            send_packet(dir_rows[k].ver, dir_rows[k].start, dir_rows[k].stop, dists, confs);
        end
        drain();

        // Random part over three setting phases and idling profiles.
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 46;
                recv_idle_pct = 20;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_MIN_CONF, (ph == 2) ? 255 : $urandom_range(0, 120));
            write_reg(REG_MAX_DIST, (ph == 1) ? 1 : $urandom_range(300, 65535));
            write_reg(REG_STOP_DIST, (ph == 1) ? 65535 : $urandom_range(1, 500));
            write_reg(REG_HOLD, (ph == 0) ? 65535 : $urandom_range(0, 20));
            write_reg(REG_FRONT_LO, (ph == 0) ? 0 : $urandom_range(30000, 35999));
            write_reg(REG_FRONT_HI, (ph == 1) ? 35999 : $urandom_range(0, 6000));
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
            end
            send_ticks($urandom_range(0, 5));
            random_packet($urandom_range(1));
            drain();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/lpod_pkg.sv
sv/lidar_packet_obstacle_detect.sv
bench/testbench.sv
